>>> sv/sorted_list_merge_core_assert.svh
// Assertion macros for the sorted list merge core.
`ifndef SORTED_LIST_MERGE_CORE_ASSERT_SVH
`define SORTED_LIST_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define SLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> sv/slm_pkg.sv
`timescale 1ns / 1ps

package slm_pkg;

	localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
	localparam logic [1:0] CMD_MERGE         = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} slm_req_t;

	typedef struct packed {
		logic signed [31:0] merged_value;
		logic               last;
	} slm_result_t;

	// controller -> datapath
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic step;
	} slm_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic final_pick;
	} slm_status_t;

endpackage

>>> sv/slm_dpath.sv
`timescale 1ns / 1ps

module slm_dpath #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [31:0]   load_value,
	input  slm_pkg::slm_ctrl_t   ctrl,
	output slm_pkg::slm_status_t status,
	output slm_pkg::slm_result_t result,
	output logic                 result_valid
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	logic signed [31:0] first_mem_q  [LIST_DEPTH];
	logic signed [31:0] second_mem_q [LIST_DEPTH];

	logic [CW-1:0] first_cnt_q, second_cnt_q;
	logic [CW-1:0] rd_first_q, rd_second_q;
	slm_pkg::slm_result_t result_q;
	logic          result_valid_q;

	logic signed [31:0] head_first, head_second;
	logic          have_first, have_second, take_first;
	logic [CW:0]   used_next, total;
	logic          first_room, second_room;

	assign head_first  = first_mem_q[rd_first_q[AW-1:0]];
	assign head_second = second_mem_q[rd_second_q[AW-1:0]];
	assign have_first  = rd_first_q < first_cnt_q;
	assign have_second = rd_second_q < second_cnt_q;
	// ties go to the second list
	assign take_first  = have_first && (!have_second || (head_first < head_second));

	assign used_next = {1'b0, rd_first_q} + {1'b0, rd_second_q} + (CW+1)'(1);
	assign total     = {1'b0, first_cnt_q} + {1'b0, second_cnt_q};

	assign first_room  = first_cnt_q < CW'(LIST_DEPTH);
	assign second_room = second_cnt_q < CW'(LIST_DEPTH);

	assign status.empty      = (total == '0);
	assign status.final_pick = (used_next == total);

	always_ff @(posedge clk) begin
		if (ctrl.load_first && first_room) begin
			first_mem_q[first_cnt_q[AW-1:0]] <= load_value;
		end
		if (ctrl.load_second && second_room) begin
			second_mem_q[second_cnt_q[AW-1:0]] <= load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q    <= '0;
			second_cnt_q   <= '0;
			rd_first_q     <= '0;
			rd_second_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctrl.step;
			if (ctrl.load_first && first_room) begin
				first_cnt_q <= first_cnt_q + CW'(1);
			end
			if (ctrl.load_second && second_room) begin
				second_cnt_q <= second_cnt_q + CW'(1);
			end
			if (ctrl.step) begin
				if (status.final_pick) begin
					first_cnt_q  <= '0;
					second_cnt_q <= '0;
					rd_first_q   <= '0;
					rd_second_q  <= '0;
				end else if (take_first) begin
					rd_first_q <= rd_first_q + CW'(1);
				end else begin
					rd_second_q <= rd_second_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			result_q.merged_value <= take_first ? head_first : head_second;
			result_q.last         <= status.final_pick;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

>>> sv/slm_ctrl.sv
`timescale 1ns / 1ps

module slm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           req_cmd,
	input  slm_pkg::slm_status_t status,
	output slm_pkg::slm_ctrl_t   ctrl,
	output logic                 busy
);

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_comb begin
		ctrl.load_first  = 1'b0;
		ctrl.load_second = 1'b0;
		ctrl.step        = (state_q == ST_MERGE);
		if (accept) begin
			case (req_cmd)
				slm_pkg::CMD_APPEND_FIRST:  ctrl.load_first  = 1'b1;
				slm_pkg::CMD_APPEND_SECOND: ctrl.load_second = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// an empty merge emits nothing and stays idle
					if (accept && (req_cmd == slm_pkg::CMD_MERGE) && !status.empty) begin
						state_q <= ST_MERGE;
						busy_q  <= 1'b1;
					end
				end
				ST_MERGE: begin
					if (status.final_pick) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

>>> sv/sorted_list_merge_core.sv
// Append transactions: a new one is accepted every cycle while busy is low.
// Merge: busy while the N stored elements are emitted; one result per cycle, the
// first in the cycle after busy rises, the last (with last set) as busy falls.
// Pace is set by the single compare/select step on the two list heads.
// arst_n clears both counts, read pointers and the result strobe; the stores
// are not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

`include "sorted_list_merge_core_assert.svh"

module sorted_list_merge_core #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  slm_pkg::slm_req_t    req,
	output logic                 busy,
	output slm_pkg::slm_result_t result,
	output logic                 result_valid
);

	// Control and status between the sequencer and the datapath.
	slm_pkg::slm_ctrl_t   ctrl;
	slm_pkg::slm_status_t status;

	// Sequencer: decodes the command of each accepted transaction and walks
	// the merge one element per cycle until the datapath flags the final pick.
	slm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_cmd (req.cmd),
		.status  (status),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	// Datapath: two element stores with fill counts, two read pointers,
	// the signed head compare (second list wins ties) and the result register.
	// Appends to a full store are dropped; counts clear on the final pick.
	slm_dpath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_value   (req.value),
		.ctrl         (ctrl),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

	// Every merge cycle produces exactly one result in the following cycle.
	`SLM_ASSERT_NEXT(a_busy_emits, clk, arst_n, busy, result_valid)
	// The final result coincides with the core going idle, others do not.
	`SLM_ASSERT_SAME(a_last_idle, clk, arst_n, result_valid && result.last, !busy)
	`SLM_ASSERT_SAME(a_mid_busy, clk, arst_n, result_valid && !result.last, busy)
	// While merging there is always something left to emit.
	`SLM_ASSERT_SAME(a_busy_nonempty, clk, arst_n, busy, !status.empty)

endmodule
